### rtl/core/gcv_pkg.sv
// ----------------------------------------------------------------------------
// gcv_pkg
// Shared widths, register indexes, operation codes and types of the GARCH
// conditional variance block.
// ----------------------------------------------------------------------------
package gcv_pkg;

	// Field widths.
	localparam int RES_W  = 32;   // residual, signed Q15.16
	localparam int VAR_W  = 48;   // variance, unsigned Q24.24
	localparam int COEF_W = 32;   // coefficients, unsigned Q2.30
	localparam int SQ_W   = 63;   // squared residual magnitude, Q31.32

	// Model order, clipped to the depth of the history lines.
	localparam int DEPTH      = 3;
	localparam int ARCH_LAGS  = 3;
	localparam int GARCH_LAGS = 3;
	localparam int ARCH_N     = (ARCH_LAGS > DEPTH) ? DEPTH : ARCH_LAGS;
	localparam int GARCH_N    = (GARCH_LAGS > DEPTH) ? DEPTH : GARCH_LAGS;

	// Digit-serial multiplier geometry: wide operand times coefficient,
	// the coefficient consumed one digit per cycle.
	localparam int DIGIT_W = 4;
	localparam int DIGITS  = COEF_W / DIGIT_W;
	localparam int MUL_A_W = SQ_W;
	localparam int PROD_W  = MUL_A_W + COEF_W;

	// Term scaling back to Q24.24.
	localparam int ARCH_SHIFT  = 38;
	localparam int GARCH_SHIFT = 30;

	// Accumulator width: const plus three ARCH terms below 2^56 and three
	// GARCH terms below 2^50 stays below 2^58.
	localparam int SUM_W = 58;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	localparam logic [CFG_IDX_W-1:0] REG_CONST   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ARCH_1  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ARCH_2  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ARCH_3  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GARCH_1 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GARCH_2 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_GARCH_3 = 3'd6;

	// Operations run per item on the shared multiplier.
	localparam int OP_W = 3;
	localparam logic [OP_W-1:0] OP_ARCH_1  = 3'd0;
	localparam logic [OP_W-1:0] OP_ARCH_2  = 3'd1;
	localparam logic [OP_W-1:0] OP_ARCH_3  = 3'd2;
	localparam logic [OP_W-1:0] OP_GARCH_1 = 3'd3;
	localparam logic [OP_W-1:0] OP_GARCH_2 = 3'd4;
	localparam logic [OP_W-1:0] OP_GARCH_3 = 3'd5;
	localparam logic [OP_W-1:0] OP_SQUARE  = 3'd6;

	// Configuration register file contents.
	typedef struct packed {
		logic [VAR_W-1:0]             const_term;
		logic [DEPTH-1:0][COEF_W-1:0] arch_coef;
		logic [DEPTH-1:0][COEF_W-1:0] garch_coef;
	} cfg_t;

	// Request to the serial multiplier.
	typedef struct packed {
		logic               start;
		logic [MUL_A_W-1:0] a;
		logic [COEF_W-1:0]  b;
	} mul_req_t;

endpackage

### rtl/core/gcv_cfg_regs.sv
// ----------------------------------------------------------------------------
// gcv_cfg_regs
// Configuration register file: constant term and the ARCH and GARCH
// coefficients, written through a valid/ready channel.
// ----------------------------------------------------------------------------
module gcv_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [gcv_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gcv_pkg::CFG_DATA_W-1:0]   cfg_data,
	output gcv_pkg::cfg_t                    cfg
);

	gcv_pkg::cfg_t cfg_q;

	// Writes are always taken.
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Register writes; an index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				gcv_pkg::REG_CONST: begin
					cfg_q.const_term <= cfg_data[gcv_pkg::VAR_W-1:0];
				end
				gcv_pkg::REG_ARCH_1: begin
					cfg_q.arch_coef[0] <= cfg_data[gcv_pkg::COEF_W-1:0];
				end
				gcv_pkg::REG_ARCH_2: begin
					cfg_q.arch_coef[1] <= cfg_data[gcv_pkg::COEF_W-1:0];
				end
				gcv_pkg::REG_ARCH_3: begin
					cfg_q.arch_coef[2] <= cfg_data[gcv_pkg::COEF_W-1:0];
				end
				gcv_pkg::REG_GARCH_1: begin
					cfg_q.garch_coef[0] <= cfg_data[gcv_pkg::COEF_W-1:0];
				end
				gcv_pkg::REG_GARCH_2: begin
					cfg_q.garch_coef[1] <= cfg_data[gcv_pkg::COEF_W-1:0];
				end
				gcv_pkg::REG_GARCH_3: begin
					cfg_q.garch_coef[2] <= cfg_data[gcv_pkg::COEF_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### rtl/core/gcv_serial_mult.sv
// ----------------------------------------------------------------------------
// gcv_serial_mult
// Digit-serial unsigned multiplier. The coefficient operand is shifted out
// one digit per cycle, least significant first; each digit adds one partial
// product into the upper accumulator while the settled low bits shift into
// a separate register.
// ----------------------------------------------------------------------------
module gcv_serial_mult (
	input  logic                           clk,
	input  logic                           arst_n,
	input  gcv_pkg::mul_req_t              req,
	output logic                           done,
	output logic [gcv_pkg::PROD_W-1:0]     product
);

	localparam int CNT_W  = $clog2(gcv_pkg::DIGITS);
	localparam int STEP_W = gcv_pkg::MUL_A_W + gcv_pkg::DIGIT_W;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(gcv_pkg::DIGITS - 1);

	logic                          busy_q;
	logic                          done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [gcv_pkg::MUL_A_W-1:0]   a_q;
	logic [gcv_pkg::COEF_W-1:0]    b_q;
	logic [gcv_pkg::MUL_A_W-1:0]   acc_q;
	logic [gcv_pkg::COEF_W-1:0]    lo_q;
	logic [STEP_W-1:0]             step;

	// One partial product per cycle: wide operand times one digit.
	assign step = STEP_W'(acc_q)
		+ STEP_W'(a_q) * STEP_W'(b_q[gcv_pkg::DIGIT_W-1:0]);

	assign product = {acc_q, lo_q};
	assign done    = done_q;

	// Digit counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and accumulator shift registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
			lo_q  <= '0;
		end else if (busy_q) begin
			acc_q <= step[STEP_W-1:gcv_pkg::DIGIT_W];
			lo_q  <= {step[gcv_pkg::DIGIT_W-1:0], lo_q[gcv_pkg::COEF_W-1:gcv_pkg::DIGIT_W]};
			b_q   <= b_q >> gcv_pkg::DIGIT_W;
		end
	end

endmodule

### rtl/core/garch_conditional_variance.sv
// ----------------------------------------------------------------------------
// garch_conditional_variance
// One residual at a time: the next is taken only once the last result is
// in the output register. Seven products (three ARCH, three GARCH, one
// square of the new residual) run in turn on the shared 4-bit digit-serial
// multiplier. Reset clears configuration, history lines and all handshakes.
// ----------------------------------------------------------------------------
module garch_conditional_variance (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration channel.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [gcv_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gcv_pkg::CFG_DATA_W-1:0]    cfg_data,
	// Input channel.
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [gcv_pkg::RES_W-1:0]  residual,
	input  logic                              restart,
	// Output channel.
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [gcv_pkg::VAR_W-1:0]         variance,
	output logic                              saturated
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	localparam logic [gcv_pkg::OP_W-1:0] OP_ARCH_LAST =
		gcv_pkg::OP_W'(gcv_pkg::ARCH_N - 1);
	localparam logic [gcv_pkg::OP_W-1:0] OP_GARCH_LAST =
		gcv_pkg::OP_W'(gcv_pkg::GARCH_N - 1) + gcv_pkg::OP_GARCH_1;
	localparam logic [gcv_pkg::SUM_W-1:0] VAR_MAX =
		gcv_pkg::SUM_W'({gcv_pkg::VAR_W{1'b1}});

	gcv_pkg::cfg_t                 cfg;
	gcv_pkg::mul_req_t             mul_req;
	logic                          mul_done;
	logic [gcv_pkg::PROD_W-1:0]    product;

	logic [1:0]                    state_q;
	logic [gcv_pkg::OP_W-1:0]      op_q;
	logic [gcv_pkg::OP_W-1:0]      op_next;
	logic [gcv_pkg::RES_W-1:0]     res_q;
	logic [gcv_pkg::RES_W-1:0]     res_mag;
	logic [gcv_pkg::SUM_W-1:0]     sum_q;
	logic [gcv_pkg::SQ_W-1:0]      new_sq_q;
	logic [gcv_pkg::SQ_W-1:0]      sq_hist_q  [gcv_pkg::DEPTH];
	logic [gcv_pkg::VAR_W-1:0]     var_hist_q [gcv_pkg::DEPTH];
	logic [gcv_pkg::SUM_W-1:0]     arch_term;
	logic [gcv_pkg::SUM_W-1:0]     garch_term;
	logic                          sum_over;
	logic [gcv_pkg::VAR_W-1:0]     sum_clip;
	logic                          out_valid_q;
	logic [gcv_pkg::VAR_W-1:0]     variance_q;
	logic                          saturated_q;
	logic                          in_xfer;
	logic                          out_free;
	logic                          finish;

	gcv_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	gcv_serial_mult u_mult (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mul_req),
		.done    (mul_done),
		.product (product)
	);

	// Handshakes.
	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign finish    = (state_q == ST_FIN) && out_free;
	assign out_valid = out_valid_q;
	assign variance  = variance_q;
	assign saturated = saturated_q;

	// Magnitude of the held residual; the most negative code maps to 2^31.
	assign res_mag = res_q[gcv_pkg::RES_W-1] ? (~res_q + 1'b1) : res_q;

	// Scale the finished product back to Q24.24.
	assign arch_term  = gcv_pkg::SUM_W'(product[gcv_pkg::PROD_W-1:gcv_pkg::ARCH_SHIFT]);
	assign garch_term = gcv_pkg::SUM_W'(product[gcv_pkg::PROD_W-1:gcv_pkg::GARCH_SHIFT]);

	// Saturation of the finished sum.
	assign sum_over = (sum_q > VAR_MAX);
	assign sum_clip = sum_over ? {gcv_pkg::VAR_W{1'b1}} : sum_q[gcv_pkg::VAR_W-1:0];

	// Next operation, skipping lags that are not part of the model.
	always_comb begin
		if (op_q == OP_ARCH_LAST) begin
			op_next = gcv_pkg::OP_GARCH_1;
		end else if (op_q == OP_GARCH_LAST) begin
			op_next = gcv_pkg::OP_SQUARE;
		end else begin
			op_next = op_q + 1'b1;
		end
	end

	// Multiplier operands for the current operation.
	always_comb begin
		mul_req.start = (state_q == ST_ISSUE);
		case (op_q)
			gcv_pkg::OP_ARCH_1: begin
				mul_req.a = sq_hist_q[0];
				mul_req.b = cfg.arch_coef[0];
			end
			gcv_pkg::OP_ARCH_2: begin
				mul_req.a = sq_hist_q[1];
				mul_req.b = cfg.arch_coef[1];
			end
			gcv_pkg::OP_ARCH_3: begin
				mul_req.a = sq_hist_q[2];
				mul_req.b = cfg.arch_coef[2];
			end
			gcv_pkg::OP_GARCH_1: begin
				mul_req.a = gcv_pkg::MUL_A_W'(var_hist_q[0]);
				mul_req.b = cfg.garch_coef[0];
			end
			gcv_pkg::OP_GARCH_2: begin
				mul_req.a = gcv_pkg::MUL_A_W'(var_hist_q[1]);
				mul_req.b = cfg.garch_coef[1];
			end
			gcv_pkg::OP_GARCH_3: begin
				mul_req.a = gcv_pkg::MUL_A_W'(var_hist_q[2]);
				mul_req.b = cfg.garch_coef[2];
			end
			default: begin
				mul_req.a = gcv_pkg::MUL_A_W'(res_mag);
				mul_req.b = res_mag;
			end
		endcase
	end

	// Sequencer: one multiplier operation at a time, then the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= gcv_pkg::OP_ARCH_1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_ISSUE;
						op_q    <= gcv_pkg::OP_ARCH_1;
					end
				end
				ST_ISSUE: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (mul_done) begin
						if (op_q == gcv_pkg::OP_SQUARE) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_ISSUE;
							op_q    <= op_next;
						end
					end
				end
				default: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// Residual capture, running sum and square of the new residual.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			res_q <= residual;
			sum_q <= gcv_pkg::SUM_W'(cfg.const_term);
		end else if ((state_q == ST_WAIT) && mul_done) begin
			if (op_q == gcv_pkg::OP_SQUARE) begin
				new_sq_q <= product[gcv_pkg::SQ_W-1:0];
			end else if (op_q >= gcv_pkg::OP_GARCH_1) begin
				sum_q <= sum_q + garch_term;
			end else begin
				sum_q <= sum_q + arch_term;
			end
		end
	end

	// History lines of squared residuals and variances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < gcv_pkg::DEPTH; i++) begin
				sq_hist_q[i]  <= '0;
				var_hist_q[i] <= '0;
			end
		end else if (in_xfer && restart) begin
			for (int i = 0; i < gcv_pkg::DEPTH; i++) begin
				sq_hist_q[i]  <= '0;
				var_hist_q[i] <= '0;
			end
		end else if (finish) begin
			for (int i = gcv_pkg::DEPTH - 1; i > 0; i--) begin
				sq_hist_q[i]  <= sq_hist_q[i-1];
				var_hist_q[i] <= var_hist_q[i-1];
			end
			sq_hist_q[0]  <= new_sq_q;
			var_hist_q[0] <= sum_clip;
		end
	end

	// Output register: holds a result until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			variance_q  <= sum_clip;
			saturated_q <= sum_over;
		end
	end

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the GARCH conditional variance block. A variance
// tracker keeps its own copy of the coefficients and of both history lines,
// predicts the variance and the saturation flag for every residual transfer,
// and compares them with the result transfers in order. Directed items cover
// extreme residuals, saturation and restarts. Random phases follow with
// several coefficient sets, and with sender and receiver idling.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import gcv_pkg::*;

	// Index 7 decodes to no register; writes to it must be dropped.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
	localparam logic [VAR_W-1:0] VAR_MAX = '1;
	localparam logic [COEF_W-1:0] ARCH_TYPICAL = 32'h2000_0000;
	localparam logic [COEF_W-1:0] GARCH_TYPICAL = 32'h4000_0000;
	localparam int PHASES = 5;
	localparam int PHASE_ITEMS = 340;
	localparam int HOLD_AFTER = 400;
	localparam int LONG_HOLD_CYCLES = 1000;

	typedef struct packed {
		logic [VAR_W-1:0] variance;
		logic             saturated;
	} variance_result_t;

	// Predicts the conditional variance from its own history lines and
	// checks the block's results against the predictions in order.
	class variance_tracker;
		logic [VAR_W-1:0]  const_term;
		logic [COEF_W-1:0] arch_coef [DEPTH];
		logic [COEF_W-1:0] garch_coef [DEPTH];
		logic [RES_W-1:0]  past_res [DEPTH];
		logic [VAR_W-1:0]  past_var [DEPTH];
		variance_result_t  expected_variances [$];
		int                errors;

		function new();
			const_term = '0;
			errors = 0;
			for (int i = 0; i < DEPTH; i++) begin
				arch_coef[i] = '0;
				garch_coef[i] = '0;
				past_res[i] = '0;
				past_var[i] = '0;
			end
		endfunction

		function void write_register(input logic [CFG_IDX_W-1:0] idx,
				input logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_CONST:   const_term = data[VAR_W-1:0];
				REG_ARCH_1:  arch_coef[0] = data[COEF_W-1:0];
				REG_ARCH_2:  arch_coef[1] = data[COEF_W-1:0];
				REG_ARCH_3:  arch_coef[2] = data[COEF_W-1:0];
				REG_GARCH_1: garch_coef[0] = data[COEF_W-1:0];
				REG_GARCH_2: garch_coef[1] = data[COEF_W-1:0];
				REG_GARCH_3: garch_coef[2] = data[COEF_W-1:0];
				default: begin
				end
			endcase
		endfunction

		// Variance of the current date from history held before this residual.
		function void accept_residual(input logic [RES_W-1:0] res, input logic clear_history);
			logic [63:0]      total;
			logic [RES_W-1:0] mag;
			logic [63:0]      sq;
			logic [95:0]      prod;
			variance_result_t r;
			if (clear_history) begin
				for (int i = 0; i < DEPTH; i++) begin
					past_res[i] = '0;
					past_var[i] = '0;
				end
			end
			total = 64'(const_term);
			for (int i = 0; i < ARCH_N; i++) begin
				mag = past_res[i][RES_W-1] ? -past_res[i] : past_res[i];
				sq = 64'(mag) * 64'(mag);
				prod = 96'(arch_coef[i]) * 96'(sq);
				total += 64'(prod >> ARCH_SHIFT);
			end
			for (int i = 0; i < GARCH_N; i++) begin
				prod = 96'(garch_coef[i]) * 96'(past_var[i]);
				total += 64'(prod >> GARCH_SHIFT);
			end
			r.saturated = (total > 64'(VAR_MAX));
			r.variance = r.saturated ? VAR_MAX : total[VAR_W-1:0];
			// The clipped value is what enters the variance history.
			for (int i = DEPTH - 1; i > 0; i--) begin
				past_res[i] = past_res[i-1];
				past_var[i] = past_var[i-1];
			end
			past_res[0] = res;
			past_var[0] = r.variance;
			expected_variances.push_back(r);
		endfunction

		function int pending();
			return expected_variances.size();
		endfunction

		task report_mismatch(input string what);
			errors++;
			$display("%0t ns MISMATCH: %s", $time, what);
		endtask

		task check_variance(input logic [VAR_W-1:0] v, input logic s);
			variance_result_t want;
			if (expected_variances.size() == 0) begin
				report_mismatch($sformatf("variance %h arrived with no residual pending", v));
				return;
			end
			want = expected_variances.pop_front();
			if (v !== want.variance)
				report_mismatch($sformatf("variance %h, expected %h", v, want.variance));
			if (s !== want.saturated)
				report_mismatch($sformatf("saturated %b, expected %b", s, want.saturated));
		endtask
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [CFG_DATA_W-1:0]    cfg_data;
	logic                     in_valid;
	logic                     in_ready;
	logic signed [RES_W-1:0]  residual;
	logic                     restart;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [VAR_W-1:0]         variance;
	logic                     saturated;

	variance_tracker tracker;
	int send_gap_pct = 0;
	int recv_gap_pct = 0;
	int variances_seen = 0;
	int hold_left = 0;
	bit long_hold_done = 1'b0;

	garch_conditional_variance dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.residual  (residual),
		.restart   (restart),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.variance  (variance),
		.saturated (saturated)
	);

	// Free-running clock.
	always #2 clk = ~clk;

	// Observe every transfer and drive the receiver side, including one long
	// hold-off that backs the block up while residuals keep being offered.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				tracker.write_register(cfg_index, cfg_data);
			if (in_valid && in_ready)
				tracker.accept_residual(residual, restart);
			if (out_valid && out_ready) begin
				tracker.check_variance(variance, saturated);
				variances_seen++;
			end
		end
		if (variances_seen == HOLD_AFTER && !long_hold_done) begin
			hold_left = LONG_HOLD_CYCLES;
			long_hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_gap_pct);
		end
	end

	// One register write; valid stays up for a following write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// Write all registers, with junk above the coefficient width, plus a write
	// to the unused index.
	task automatic program_model(input logic [VAR_W-1:0] c,
			input logic [COEF_W-1:0] a1, a2, a3, g1, g2, g3);
		write_reg(REG_CONST, c);
		write_reg(REG_ARCH_1, {16'($urandom), a1});
		write_reg(REG_ARCH_2, {16'($urandom), a2});
		write_reg(REG_ARCH_3, {16'($urandom), a3});
		write_reg(REG_GARCH_1, {16'($urandom), g1});
		write_reg(REG_GARCH_2, {16'($urandom), g2});
		write_reg(REG_GARCH_3, {16'($urandom), g3});
		write_reg(REG_SPARE, 48'({$urandom, $urandom}));
		cfg_valid <= 1'b0;
	endtask

	// Offer one residual, sometimes after idle cycles, and wait for its transfer.
	// Each cycle before the offer idles with the sender's idle percentage.
	task automatic send_residual(input logic [RES_W-1:0] res, input logic clear);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		residual <= res;
		restart <= clear;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Stop offering and wait until every predicted variance has been checked.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [COEF_W-1:0] pick_coef(input logic [COEF_W-1:0] typical);
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return $urandom_range(0, typical);
		endcase
	endfunction

	function automatic logic [VAR_W-1:0] pick_const();
		case ($urandom_range(9))
			0: return '0;
			1: return VAR_MAX;
			2: return 48'({$urandom, $urandom});
			default: return 48'($urandom_range(0, 32'h0400_0000));
		endcase
	endfunction

	// Mostly market-sized residuals, with full-range values and extremes.
	function automatic logic [RES_W-1:0] pick_residual();
		logic [RES_W-1:0] mag;
		case ($urandom_range(7))
			0, 1: return $urandom;
			2: begin
				case ($urandom_range(4))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0001;
					3: return 32'hFFFF_FFFF;
					default: return '0;
				endcase
			end
			default: begin
				mag = $urandom_range(0, 32'h0004_0000);
				return $urandom_range(1) ? -mag : mag;
			end
		endcase
	endfunction

	// Main sequence.
	initial begin
		tracker = new();
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		residual <= '0;
		restart <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extreme residuals with large weights: saturation feeds the history.
		program_model(48'h0000_0100_0000, '1, 32'h4000_0000, 32'h0000_0001,
			32'h8000_0000, '1, '0);
		send_residual(32'h7FFF_FFFF, 1'b1);
		send_residual(32'h8000_0000, 1'b0);
		send_residual(32'h0000_0000, 1'b0);
		send_residual(32'h0000_0001, 1'b0);
		send_residual(32'hFFFF_FFFF, 1'b0);
		send_residual(32'h0001_0000, 1'b1);
		send_residual(32'h0002_0000, 1'b0);
		send_residual(32'hFFFE_0000, 1'b0);
		send_residual(32'h0000_0000, 1'b0);
		send_residual(32'h0000_0000, 1'b0);
		send_residual(32'h0000_0000, 1'b0);
		drain();

		// Constant at full scale: the smallest variance weight tips it over.
		program_model(VAR_MAX, '0, '0, '0, 32'h0000_0001, '0, '0);
		send_residual(32'h8000_0000, 1'b1);
		send_residual(32'h8000_0000, 1'b0);
		send_residual(32'h0000_0000, 1'b0);
		send_residual(32'h0000_0005, 1'b1);
		drain();

		// Zero constant with every weight at full scale.
		program_model('0, '1, '1, '1, '1, '1, '1);
		send_residual(32'h0000_0000, 1'b1);
		send_residual(32'h0000_0000, 1'b0);
		send_residual(32'h8000_0000, 1'b0);
		send_residual(32'h0000_0000, 1'b0);
		send_residual(32'h0000_0000, 1'b1);
		drain();

		// Random phases, each with its own coefficient set and idling pattern.
		for (int phase = 0; phase < PHASES; phase++) begin
			send_gap_pct = (phase < 2) ? 7 : (phase < 4) ? 50 : 0;
			recv_gap_pct = (phase < 2) ? 50 : (phase < 4) ? 7 : 0;
			program_model(pick_const(), pick_coef(ARCH_TYPICAL), pick_coef(ARCH_TYPICAL),
				pick_coef(ARCH_TYPICAL), pick_coef(GARCH_TYPICAL),
				pick_coef(GARCH_TYPICAL), pick_coef(GARCH_TYPICAL));
			repeat (PHASE_ITEMS)
				send_residual(pick_residual(), $urandom_range(59) == 0);
			drain();
		end

		repeat (80) @(posedge clk);
		if (tracker.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog.
	initial begin
		#4ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
